// ----- src/c1l_pkg.sv -----
// ----------------------------------------------------------------------------
// c1l_pkg
// Shared types, constants and the Crypto-1 filter for the LFSR lane bank.
// ----------------------------------------------------------------------------
package c1l_pkg;

  localparam int LANES = 64;
  localparam int IDX_W = (LANES > 1) ? $clog2(LANES) : 1;

  localparam int STATE_W = 48;
  localparam int BITS_W  = 64;

  // Feedback taps in slot order (slot 47-k holds x_k).
  localparam logic [STATE_W-1:0] TAPS_NO_X0 = 48'h046B_50D4_1170;
  localparam logic [STATE_W-1:0] TAPS_ALL   = 48'h846B_50D4_1170;

  localparam logic [31:0] FILT_A   = 32'h000F_22C0;
  localparam logic [31:0] FILT_B   = 32'h0006_C9C0;
  localparam logic [31:0] FILT_C   = 32'h0003_C8B0;
  localparam logic [31:0] FILT_D   = 32'h0001_E458;
  localparam logic [31:0] FILT_E   = 32'h0000_D938;
  localparam logic [31:0] FILT_OUT = 32'hEC57_E80A;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_STEP = 2'd1,
    OP_BACK = 2'd2,
    OP_READ = 2'd3
  } c1l_op_e;

  typedef struct packed {
    logic accept;
    logic fwd;
    logic back;
    logic enc;
  } c1l_ctrl_t;

  // 20-input filter over the even slots.
  function automatic logic filter20(logic [STATE_W-1:0] s);
    logic [19:0] x;
    logic [4:0]  f;
    for (int j = 0; j < 20; j++) begin
      x[j] = s[2*j];
    end
    f[4] = FILT_A[5'(x[3:0])   + 5'd4];
    f[3] = FILT_B[5'(x[7:4])   + 5'd3];
    f[2] = FILT_C[5'(x[11:8])  + 5'd2];
    f[1] = FILT_D[5'(x[15:12]) + 5'd1];
    f[0] = FILT_E[5'(x[19:16])];
    return FILT_OUT[f];
  endfunction

endpackage

// ----- src/c1l_if.sv -----
// ----------------------------------------------------------------------------
// c1l_if
// Valid/ready channel interfaces for the LFSR lane bank.
// ----------------------------------------------------------------------------
interface c1l_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [5:0]  lane_index;
  logic [47:0] state_value;
  logic [63:0] input_bits;
  logic        encrypted;

  modport source (
    output valid, opcode, lane_index, state_value, input_bits, encrypted,
    input  ready
  );
  modport sink (
    input  valid, opcode, lane_index, state_value, input_bits, encrypted,
    output ready
  );
endinterface

interface c1l_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] keystream_bits;
  logic [47:0] lane_state;

  modport source (
    output valid, keystream_bits, lane_state,
    input  ready
  );
  modport sink (
    input  valid, keystream_bits, lane_state,
    output ready
  );
endinterface

// ----- src/crypto1_lfsr_lanes_unit.sv -----
// ----------------------------------------------------------------------------
// crypto1_lfsr_lanes_unit
// Bank of Crypto-1 48-bit LFSR lanes with load, step, rollback and readback.
//
//   channel | dir | word contents
//   --------+-----+-----------------------------------------------------
//   req_i   | in  | opcode, lane_index, state_value, input_bits, encrypted
//   rsp_o   | out | keystream_bits, lane_state
//
// One word per cycle while the output register can take it: all lanes
// update and the result is registered at the edge that takes the word.
// Throughput is set by the single output register: a new word is taken
// whenever that register is empty or is being drained in the same cycle.
// Reset clears every lane to zero; no clearing pass.
// ----------------------------------------------------------------------------
module crypto1_lfsr_lanes_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  c1l_in_if.sink    req_i,
  c1l_out_if.source rsp_o
);

  logic                        out_valid_q, out_valid_d;
  logic                        accept;
  c1l_pkg::c1l_ctrl_t          ctrl;
  logic [c1l_pkg::STATE_W-1:0] lanes_state [c1l_pkg::LANES];
  logic [c1l_pkg::LANES-1:0]   ks;

  assign req_i.ready = !out_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  assign ctrl.accept = accept;
  assign ctrl.fwd    = req_i.opcode == c1l_pkg::OP_STEP;
  assign ctrl.back   = req_i.opcode == c1l_pkg::OP_BACK;
  assign ctrl.enc    = req_i.encrypted;

  for (genvar l = 0; l < c1l_pkg::LANES; l++) begin : g_lane
    c1l_lane u_lane (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .load_i       ((req_i.opcode == c1l_pkg::OP_LOAD) && (req_i.lane_index == 6'(l))),
      .load_value_i (req_i.state_value),
      .in_bit_i     (req_i.input_bits[l]),
      .state_o      (lanes_state[l]),
      .ks_o         (ks[l])
    );
  end

  c1l_merge u_merge (
    .clk_i            (clk_i),
    .accept_i         (accept),
    .lane_index_i     (req_i.lane_index),
    .lanes_state_i    (lanes_state),
    .ks_i             (ks),
    .keystream_bits_o (rsp_o.keystream_bits),
    .lane_state_o     (rsp_o.lane_state)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign rsp_o.valid = out_valid_q;

endmodule

// ----- src/c1l_lane.sv -----
// ----------------------------------------------------------------------------
// c1l_lane
// One Crypto-1 48-bit LFSR: load, forward step or rollback per word.
// ----------------------------------------------------------------------------
module c1l_lane (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  c1l_pkg::c1l_ctrl_t                ctrl_i,
  input  logic                              load_i,
  input  logic [c1l_pkg::STATE_W-1:0]       load_value_i,
  input  logic                              in_bit_i,
  output logic [c1l_pkg::STATE_W-1:0]       state_o,
  output logic                              ks_o
);

  logic [c1l_pkg::STATE_W-1:0] state_q, state_d;
  logic [c1l_pkg::STATE_W-1:0] back_n;
  logic fwd_ks, back_ks, fwd_fb, back_fb;

  assign back_n  = {1'b0, state_q[c1l_pkg::STATE_W-1:1]};
  assign fwd_ks  = c1l_pkg::filter20(state_q);
  assign back_ks = c1l_pkg::filter20(back_n);
  assign fwd_fb  = (^(state_q & c1l_pkg::TAPS_ALL)) ^ in_bit_i ^ (ctrl_i.enc & fwd_ks);
  assign back_fb = state_q[0] ^ (ctrl_i.enc & back_ks)
                 ^ (^(back_n & c1l_pkg::TAPS_NO_X0)) ^ in_bit_i;

  always_comb begin
    state_d = state_q;
    if (ctrl_i.accept) begin
      if (load_i) begin
        state_d = load_value_i;
      end else if (ctrl_i.fwd) begin
        state_d = {state_q[c1l_pkg::STATE_W-2:0], fwd_fb};
      end else if (ctrl_i.back) begin
        state_d = {back_fb, state_q[c1l_pkg::STATE_W-1:1]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  assign state_o = state_d;
  assign ks_o    = (ctrl_i.fwd & fwd_ks) | (ctrl_i.back & back_ks);

endmodule

// ----- src/c1l_merge.sv -----
// ----------------------------------------------------------------------------
// c1l_merge
// Gathers lane keystream bits and the addressed lane state into the
// output word register.
// ----------------------------------------------------------------------------
module c1l_merge (
  input  logic                              clk_i,
  input  logic                              accept_i,
  input  logic [5:0]                        lane_index_i,
  input  logic [c1l_pkg::STATE_W-1:0]       lanes_state_i [c1l_pkg::LANES],
  input  logic [c1l_pkg::LANES-1:0]         ks_i,
  output logic [c1l_pkg::BITS_W-1:0]        keystream_bits_o,
  output logic [c1l_pkg::STATE_W-1:0]       lane_state_o
);

  logic [c1l_pkg::STATE_W-1:0] sel_state;
  logic [c1l_pkg::BITS_W-1:0]  ks_wide;
  logic                        idx_ok;

  assign idx_ok    = int'(lane_index_i) < c1l_pkg::LANES;
  assign sel_state = idx_ok ? lanes_state_i[lane_index_i[c1l_pkg::IDX_W-1:0]] : '0;
  assign ks_wide   = c1l_pkg::BITS_W'(ks_i);

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      keystream_bits_o <= ks_wide;
      lane_state_o     <= sel_state;
    end
  end

endmodule

// ----- src/c1l_checker.sv -----
// ----------------------------------------------------------------------------
// c1l_checker
// Port-level checks for the LFSR lane bank, bound to the top level.
// ----------------------------------------------------------------------------
module c1l_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic [1:0]  opcode_i,
  input logic [5:0]  lane_index_i,
  input logic [47:0] state_value_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [63:0] keystream_bits_i,
  input logic [47:0] lane_state_i
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // Output word holds until taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(lane_state_i)
                                    && $stable(keystream_bits_i))
    else $error("output word dropped or changed while stalled");

  // Empty output register never back-pressures the input.
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output register");

  // Load and read produce no keystream.
  a_ks_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (opcode_i == c1l_pkg::OP_LOAD || opcode_i == c1l_pkg::OP_READ)
    |=> out_valid_i && keystream_bits_i == '0)
    else $error("keystream nonzero for load or read");

  // A load reads back the loaded value.
  a_load_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && opcode_i == c1l_pkg::OP_LOAD && int'(lane_index_i) < c1l_pkg::LANES
    |=> out_valid_i && lane_state_i == $past(state_value_i))
    else $error("loaded state not returned");

endmodule

bind crypto1_lfsr_lanes_unit c1l_checker u_c1l_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (req_i.valid),
  .in_ready_i       (req_i.ready),
  .opcode_i         (req_i.opcode),
  .lane_index_i     (req_i.lane_index),
  .state_value_i    (req_i.state_value),
  .out_valid_i      (rsp_o.valid),
  .out_ready_i      (rsp_o.ready),
  .keystream_bits_i (rsp_o.keystream_bits),
  .lane_state_i     (rsp_o.lane_state)
);

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Crypto-1 LFSR lane bank. A queue of request
// words (directed corner cases, then random loads, reads, single steps and
// rollbacks, and walk/unwind sequences) feeds a valid/ready driver with random
// gaps. Every accepted word runs through a bit-level lane model, and the
// monitor checks each result word against the oldest prediction under random
// backpressure, including one long hold-off that fills the block.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD      = 300;
  localparam int RANDOM_WORDS   = 2000;

  typedef struct {
    c1l_pkg::c1l_op_e op;
    logic [5:0]       idx;
    logic [47:0]      val;
    logic [63:0]      bits;
    logic             enc;
  } lane_word_t;

  typedef struct {
    logic [63:0] keystream;
    logic [47:0] state;
  } lane_rsp_t;

  function automatic logic [47:0] slot_of(int k);
    return 48'd1 << (47 - k);
  endfunction

  // feedback taps x0 x5 x9 x10 x12 x14 x15 x17 x19 x24 x25 x27 x29 x35 x39 x41 x42 x43
  localparam logic [47:0] FB_TAPS_NO_X0 =
    slot_of(5) | slot_of(9) | slot_of(10) | slot_of(12) | slot_of(14) | slot_of(15) |
    slot_of(17) | slot_of(19) | slot_of(24) | slot_of(25) | slot_of(27) | slot_of(29) |
    slot_of(35) | slot_of(39) | slot_of(41) | slot_of(42) | slot_of(43);
  localparam logic [47:0] FB_TAPS = FB_TAPS_NO_X0 | slot_of(0);

  logic clk_i = 1'b0;
  logic rst_ni;

  c1l_in_if  req_if ();
  c1l_out_if rsp_if ();

  crypto1_lfsr_lanes_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  lane_word_t  pending_words [$];
  lane_rsp_t   expected_rsps [$];
  logic [47:0] lane_model [c1l_pkg::LANES] = '{default: '0};
  lane_word_t  cur_word;
  int          gap_cnt;
  int          words_sent;
  int          stall_cnt;
  int          hold_cnt;
  bit          hold_done;
  int          results_seen;
  int          fail_cnt = 0;
  int          idle_cycles = 0;

  // 20-input filter over the even slots
  function automatic logic keystream_bit(logic [47:0] s);
    logic [19:0] g;
    logic [31:0] f;
    for (int j = 0; j < 20; j++) begin
      g[j] = s[2*j];
    end
    f = ((32'h000F_22C0 >> g[3:0])   & 32'd16) |
        ((32'h0006_C9C0 >> g[7:4])   & 32'd8)  |
        ((32'h0003_C8B0 >> g[11:8])  & 32'd4)  |
        ((32'h0001_E458 >> g[15:12]) & 32'd2)  |
        ((32'h0000_D938 >> g[19:16]) & 32'd1);
    return 1'((32'hEC57_E80A >> f[4:0]) & 32'd1);
  endfunction

  task automatic predict_word(input lane_word_t w);
    logic [63:0] ks;
    logic [47:0] s;
    logic [47:0] n;
    logic [47:0] st;
    logic        k;
    logic        fb;
    ks = '0;
    case (w.op)
      c1l_pkg::OP_LOAD: begin
        if (int'(w.idx) < c1l_pkg::LANES) lane_model[w.idx] = w.val;
      end
      c1l_pkg::OP_STEP: begin
        for (int l = 0; l < c1l_pkg::LANES; l++) begin
          s = lane_model[l];
          k = keystream_bit(s);
          fb = (^(s & FB_TAPS)) ^ w.bits[l] ^ (w.enc & k);
          lane_model[l] = {s[46:0], fb};
          ks[l] = k;
        end
      end
      c1l_pkg::OP_BACK: begin
        for (int l = 0; l < c1l_pkg::LANES; l++) begin
          s = lane_model[l];
          n = {1'b0, s[47:1]};
          k = keystream_bit(n);
          fb = s[0] ^ (w.enc & k) ^ (^(n & FB_TAPS_NO_X0)) ^ w.bits[l];
          lane_model[l] = {fb, n[46:0]};
          ks[l] = k;
        end
      end
      default: ;
    endcase
    st = (int'(w.idx) < c1l_pkg::LANES) ? lane_model[w.idx] : '0;
    expected_rsps.push_back('{keystream: ks, state: st});
  endtask

  task automatic queue_word(input c1l_pkg::c1l_op_e op, input logic [5:0] idx,
                            input logic [47:0] val, input logic [63:0] bits,
                            input logic enc);
    lane_word_t w;
    w.op = op;
    w.idx = idx;
    w.val = val;
    w.bits = bits;
    w.enc = enc;
    pending_words.push_back(w);
  endtask

  function automatic logic [47:0] rand_state();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 16) return '1;
    return 48'({$urandom(), $urandom()});
  endfunction

  function automatic logic [63:0] rand_bits();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 16) return '1;
    return {$urandom(), $urandom()};
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid       <= 1'b0;
      req_if.opcode      <= c1l_pkg::OP_READ;
      req_if.lane_index  <= '0;
      req_if.state_value <= '0;
      req_if.input_bits  <= '0;
      req_if.encrypted   <= 1'b0;
      gap_cnt = 0;
      words_sent = 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        predict_word(cur_word);
        words_sent++;
        gap_cnt = ((words_sent / 150) % 4 == 1) ? 0 : pick_gap();
      end
      if (!req_if.valid || req_if.ready) begin
        if (gap_cnt > 0) begin
          gap_cnt--;
          req_if.valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          cur_word = pending_words.pop_front();
          req_if.opcode      <= cur_word.op;
          req_if.lane_index  <= cur_word.idx;
          req_if.state_value <= cur_word.val;
          req_if.input_bits  <= cur_word.bits;
          req_if.encrypted   <= cur_word.enc;
          req_if.valid       <= 1'b1;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver backpressure
  always @(posedge clk_i or negedge rst_ni) begin
    lane_rsp_t exp_rsp;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      stall_cnt = 0;
      hold_cnt = 0;
      hold_done = 1'b0;
      results_seen = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        results_seen++;
        if (expected_rsps.size() == 0) begin
          $error("result word with nothing expected: keystream_bits %h lane_state %h",
                 rsp_if.keystream_bits, rsp_if.lane_state);
          fail_cnt++;
        end else begin
          exp_rsp = expected_rsps.pop_front();
          if (rsp_if.keystream_bits !== exp_rsp.keystream) begin
            $error("keystream_bits mismatch: expected %h actual %h",
                   exp_rsp.keystream, rsp_if.keystream_bits);
            fail_cnt++;
          end
          if (rsp_if.lane_state !== exp_rsp.state) begin
            $error("lane_state mismatch: expected %h actual %h",
                   exp_rsp.state, rsp_if.lane_state);
            fail_cnt++;
          end
        end
        if (results_seen == 400 && !hold_done) begin
          hold_cnt = LONG_HOLD;
          hold_done = 1'b1;
        end
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        rsp_if.ready <= 1'b0;
      end else if (stall_cnt > 0) begin
        stall_cnt--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
        if ((results_seen / 150) % 4 != 2) begin
          case ($urandom_range(0, 99)) inside
            [0:24]:  stall_cnt = $urandom_range(1, 3);
            [25:27]: stall_cnt = $urandom_range(10, 40);
            default: stall_cnt = 0;
          endcase
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic [63:0] walk_bits [16];
    logic        walk_enc  [16];
    logic [63:0] b;
    logic [47:0] v;
    int          n;
    int          r;
    bit          fwd_first;

    rst_ni = 1'b0;

    // directed corners
    queue_word(c1l_pkg::OP_READ, 6'd0,  '0, '0, 1'b0);
    queue_word(c1l_pkg::OP_READ, 6'd63, '1, '1, 1'b1);
    queue_word(c1l_pkg::OP_STEP, 6'd0,  '0, '0, 1'b0);
    queue_word(c1l_pkg::OP_BACK, 6'd0,  '0, '0, 1'b0);
    queue_word(c1l_pkg::OP_LOAD, 6'd0,  '1, '0, 1'b0);
    queue_word(c1l_pkg::OP_LOAD, 6'd63, 48'h8000_0000_0001, '1, 1'b1);
    v = rand_state();
    queue_word(c1l_pkg::OP_LOAD, 6'd31, v, '0, 1'b0);
    queue_word(c1l_pkg::OP_STEP, 6'd0,  '0, '1, 1'b0);
    b = {$urandom(), $urandom()};
    queue_word(c1l_pkg::OP_STEP, 6'd63, '0, b, 1'b1);
    queue_word(c1l_pkg::OP_BACK, 6'd63, '0, b, 1'b1);
    queue_word(c1l_pkg::OP_BACK, 6'd0,  '0, '1, 1'b0);
    queue_word(c1l_pkg::OP_READ, 6'd0,  '0, '0, 1'b0);
    queue_word(c1l_pkg::OP_READ, 6'd31, '0, '0, 1'b0);
    queue_word(c1l_pkg::OP_LOAD, 6'd0,  '0, '0, 1'b0);
    queue_word(c1l_pkg::OP_STEP, 6'd0,  '0, '0, 1'b1);
    queue_word(c1l_pkg::OP_STEP, 6'd63, '0, '1, 1'b1);
    queue_word(c1l_pkg::OP_BACK, 6'd63, '0, '1, 1'b1);
    queue_word(c1l_pkg::OP_BACK, 6'd0,  '0, '0, 1'b1);
    queue_word(c1l_pkg::OP_READ, 6'd63, '0, '0, 1'b0);

    // random traffic, mostly walk/unwind sequences over loaded lanes
    while (pending_words.size() < RANDOM_WORDS + 19) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        queue_word(c1l_pkg::OP_LOAD, 6'($urandom_range(0, c1l_pkg::LANES - 1)),
                   rand_state(), rand_bits(), 1'($urandom_range(0, 1)));
      end else if (r < 22) begin
        queue_word(c1l_pkg::OP_READ, 6'($urandom_range(0, 63)), rand_state(), rand_bits(),
                   1'($urandom_range(0, 1)));
      end else if (r < 35) begin
        queue_word($urandom_range(0, 1) ? c1l_pkg::OP_STEP : c1l_pkg::OP_BACK,
                   6'($urandom_range(0, 63)), rand_state(), rand_bits(),
                   1'($urandom_range(0, 1)));
      end else begin
        n = $urandom_range(1, 16);
        fwd_first = ($urandom_range(0, 3) != 0);
        for (int i = 0; i < n; i++) begin
          walk_bits[i] = rand_bits();
          walk_enc[i] = 1'($urandom_range(0, 1));
          queue_word(fwd_first ? c1l_pkg::OP_STEP : c1l_pkg::OP_BACK,
                     6'($urandom_range(0, 63)), rand_state(), walk_bits[i], walk_enc[i]);
        end
        for (int i = n - 1; i >= 0; i--) begin
          queue_word(fwd_first ? c1l_pkg::OP_BACK : c1l_pkg::OP_STEP,
                     6'($urandom_range(0, 63)), rand_state(), walk_bits[i], walk_enc[i]);
        end
        queue_word(c1l_pkg::OP_READ, 6'($urandom_range(0, 63)), rand_state(), rand_bits(),
                   1'b0);
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_words.size() > 0 || req_if.valid) @(posedge clk_i);
    while (expected_rsps.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (fail_cnt == 0 && expected_rsps.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
